// File: hw/rtl/mefvu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mefvu_pkg
// Shared types and constants of the mesh edge-flip vertex update block:
// item structs, table entry layout, field widths and codes.
// ----------------------------------------------------------------------------
package mefvu_pkg;

    // default table size in vertices per dimension
    localparam int unsigned MAX_NODES_DEF = 4096;

    // field widths
    localparam int unsigned CMD_W     = 1;
    localparam int unsigned LOC_W     = 4;
    localparam int unsigned DIM_W     = 2;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned NODE_W    = 12;
    localparam int unsigned MESH_W    = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // widths of derived mesh quantities
    localparam int unsigned MXY_W = 9;   // mesh_x * mesh_y, at most 256
    localparam int unsigned P_W   = 13;  // mesh_x * mesh_y * mesh_z, at most 4096

    // clamp limits of a mesh size
    localparam logic [MESH_W-1:0] MESH_MIN = 5'd1;
    localparam logic [MESH_W-1:0] MESH_MAX = 5'd16;

    // commands
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b1;

    // dimensions
    localparam logic [DIM_W-1:0] DIM_X    = 2'd0;
    localparam logic [DIM_W-1:0] DIM_Y    = 2'd1;
    localparam logic [DIM_W-1:0] DIM_Z    = 2'd2;
    localparam logic [DIM_W-1:0] DIM_NONE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_Z = 2'd2;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [LOC_W-1:0]         old_loc;
        logic [LOC_W-1:0]         new_loc;
        logic [DIM_W-1:0]         dim;
        logic signed [ACC_W-1:0]  weight;
        logic [NODE_W-1:0]        neighbor;
        logic [NODE_W-1:0]        home_node;
        logic signed [ACC_W-1:0]  load_same;
        logic signed [ACC_W-1:0]  load_above;
        logic signed [ACC_W-1:0]  load_below;
    } in_item_t;

    // result item
    typedef struct packed {
        logic                     affected;
        logic signed [ACC_W-1:0]  same_value;
        logic signed [ACC_W-1:0]  above_value;
        logic signed [ACC_W-1:0]  below_value;
        logic                     error;
    } out_item_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic signed [ACC_W-1:0]  same;
        logic signed [ACC_W-1:0]  above;
        logic signed [ACC_W-1:0]  below;
    } entry_t;

    localparam int unsigned ENTRY_W = 3 * ACC_W;

endpackage
`default_nettype wire

// File: hw/rtl/mesh_edge_flip_vertex_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_edge_flip_vertex_update
// Per-dimension, per-vertex table of three saturating Q16.16 accumulators,
// updated by edge-flip items and written by load items.
// ----------------------------------------------------------------------------
// Usage:
// - input channel s_valid/s_ready/s_item takes one item at a time; the result
//   channel m_valid/m_ready/m_item returns one item for every input item
// - configuration: cfg_wr_en/cfg_addr/cfg_wr_data writes one of mesh_x,
//   mesh_y, mesh_z as cfg_addr selects; write only while no item is in flight
// - load items and rejected items: the check state goes straight to the
//   response state, and the next item is accepted once the result is issued
// - update items run a 1-bit-per-cycle restoring divider over the 12-bit
//   node number: one divider pass for dimensions x and z, two for
//   dimension y (node / mesh_x, then modulo mesh_y); the divider sets
//   the rate of updates while the result channel does not stall
// - the table sits in one single-port RAM: one read in the check cycle, one
//   write when the result is issued, so no two accesses overlap
// - after reset a clearing pass zeroes all 3 * MAX_NODES table entries
//   (12288 by default); s_ready stays low meanwhile, config writes are taken
// - a finished result waits in the output register while m_ready is low;
//   a new item may be accepted in that time, and its own result waits
//   until the register is free
// ----------------------------------------------------------------------------
module mesh_edge_flip_vertex_update #(
    parameter int unsigned MAX_NODES = mefvu_pkg::MAX_NODES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire mefvu_pkg::in_item_t                 s_item,
    // result items
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output mefvu_pkg::out_item_t                     m_item,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [mefvu_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [mefvu_pkg::MESH_W-1:0]        cfg_wr_data
);

    import mefvu_pkg::*;

    localparam int unsigned DEPTH  = 3 * MAX_NODES;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned IW     = (AW > P_W + DIM_W) ? AW : P_W + DIM_W;
    localparam int unsigned CMP_W  = 17;
    localparam int unsigned CNT_W  = $clog2(NODE_W);
    localparam int unsigned SAT_W  = ACC_W + 2;

    localparam logic [CMP_W-1:0] MAX_NODES_C = CMP_W'(MAX_NODES);
    localparam logic [AW-1:0]    LAST_ADDR   = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] LAST_STEP   = CNT_W'(NODE_W - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    // saturating add of a widened delta onto an accumulator
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [SAT_W-1:0] delta
    );
        logic signed [SAT_W-1:0] s;
        logic signed [ACC_W-1:0] r;
        s = {{2{acc[ACC_W-1]}}, acc} + delta;
        if ((s[SAT_W-1:ACC_W-1] == '0) || (s[SAT_W-1:ACC_W-1] == '1)) begin
            r = s[ACC_W-1:0];
        end else if (s[SAT_W-1]) begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [MESH_W-1:0] mesh_x_reg, mesh_y_reg, mesh_z_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg;
    in_item_t          item_reg;
    logic              err_reg;
    logic [LOC_W-1:0]  loc_reg;

    // divider registers
    logic [NODE_W-1:0] quo_reg;
    logic [MXY_W-1:0]  rem_reg;
    logic [MXY_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pass2_reg;

    // clamped mesh sizes and node count
    logic [MESH_W-1:0] mx, my, mz;
    logic [MXY_W-1:0]  mxy;
    logic [P_W-1:0]    p;

    always_comb begin
        mx = (mesh_x_reg == '0) ? MESH_MIN : ((mesh_x_reg > MESH_MAX) ? MESH_MAX : mesh_x_reg);
        my = (mesh_y_reg == '0) ? MESH_MIN : ((mesh_y_reg > MESH_MAX) ? MESH_MAX : mesh_y_reg);
        mz = (mesh_z_reg == '0) ? MESH_MIN : ((mesh_z_reg > MESH_MAX) ? MESH_MAX : mesh_z_reg);
        mxy = {4'd0, mx} * {4'd0, my};
        p   = {4'd0, mxy} * {8'd0, mz};
    end

    // range check and table index of the held item
    logic          err_c;
    logic [IW-1:0] idx_wide;
    logic [AW-1:0] idx;

    always_comb begin
        err_c = (item_reg.dim == DIM_NONE)
             || ({{(CMP_W-P_W){1'b0}}, p} > MAX_NODES_C)
             || ({1'b0, item_reg.neighbor} >= p)
             || ({1'b0, item_reg.home_node} >= p);
        idx_wide = IW'(item_reg.dim) * IW'(p) + IW'(item_reg.neighbor);
        idx = idx_wide[AW-1:0];
    end

    // one restoring division step
    logic [MXY_W:0]    trial;
    logic              qbit;
    logic [MXY_W-1:0]  rem_step;
    logic [NODE_W-1:0] quo_step;

    always_comb begin
        trial    = {rem_reg, quo_reg[NODE_W-1]};
        qbit     = (trial >= {1'b0, divisor_reg});
        rem_step = qbit ? MXY_W'(trial - {1'b0, divisor_reg}) : trial[MXY_W-1:0];
        quo_step = {quo_reg[NODE_W-2:0], qbit};
    end

    // table memory
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    entry_t            rd_entry, upd_entry;

    mefvu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .rd_en   (ram_re),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // accumulator update against the decoded coordinate
    logic                    upd_aff;
    logic signed [SAT_W-1:0] w_pos, w_neg;
    logic signed [ACC_W-1:0] same_p, same_m, above_p, above_m, below_p, below_m;

    always_comb begin
        w_pos   = {{2{item_reg.weight[ACC_W-1]}}, item_reg.weight};
        w_neg   = -w_pos;
        same_p  = sat_add(rd_entry.same, w_pos);
        same_m  = sat_add(rd_entry.same, w_neg);
        above_p = sat_add(rd_entry.above, w_pos);
        above_m = sat_add(rd_entry.above, w_neg);
        below_p = sat_add(rd_entry.below, w_pos);
        below_m = sat_add(rd_entry.below, w_neg);

        upd_entry = rd_entry;
        upd_aff   = 1'b0;
        if (item_reg.old_loc < loc_reg && item_reg.new_loc >= loc_reg) begin
            upd_entry.same  = same_p;
            upd_entry.below = below_m;
            upd_aff         = 1'b1;
        end else if (item_reg.old_loc > loc_reg && item_reg.new_loc <= loc_reg) begin
            upd_entry.same  = same_p;
            upd_entry.above = above_m;
            upd_aff         = 1'b1;
        end else if (item_reg.old_loc == loc_reg && item_reg.new_loc < loc_reg) begin
            upd_entry.same  = same_m;
            upd_entry.below = below_p;
            upd_aff         = 1'b1;
        end else if (item_reg.old_loc == loc_reg && item_reg.new_loc > loc_reg) begin
            upd_entry.same  = same_m;
            upd_entry.above = above_p;
            upd_aff         = 1'b1;
        end
    end

    // result item and entry to write back
    out_item_t res_c;
    entry_t    wb_entry;

    always_comb begin
        if (item_reg.cmd == CMD_LOAD) begin
            wb_entry.same  = item_reg.load_same;
            wb_entry.above = item_reg.load_above;
            wb_entry.below = item_reg.load_below;
        end else begin
            wb_entry = upd_entry;
        end
        if (err_reg) begin
            res_c = '0;
            res_c.error = 1'b1;
        end else begin
            res_c.affected    = (item_reg.cmd == CMD_LOAD) ? 1'b1 : upd_aff;
            res_c.same_value  = wb_entry.same;
            res_c.above_value = wb_entry.above;
            res_c.below_value = wb_entry.below;
            res_c.error       = 1'b0;
        end
    end

    // handshakes
    logic s_fire, out_free, resp_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign resp_fire = (state_reg == ST_RESP) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // memory port control
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = idx;
        ram_wdata = wb_entry;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_CHECK) begin
            ram_re = !err_c && (item_reg.cmd == CMD_UPDATE);
        end else if (resp_fire) begin
            ram_we = !err_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (err_c || item_reg.cmd == CMD_LOAD) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == LAST_STEP && !pass2_reg) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (resp_fire) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            mesh_x_reg   <= MESH_MIN;
            mesh_y_reg   <= MESH_MIN;
            mesh_z_reg   <= MESH_MIN;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MESH_X: mesh_x_reg <= cfg_wr_data;
                    CFG_MESH_Y: mesh_y_reg <= cfg_wr_data;
                    CFG_MESH_Z: mesh_z_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // item, divider and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
        if (resp_fire) begin
            m_item_reg <= res_c;
        end
        if (state_reg == ST_CHECK) begin
            err_reg     <= err_c;
            quo_reg     <= item_reg.home_node;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            divisor_reg <= (item_reg.dim == DIM_Z) ? mxy : {4'd0, mx};
            pass2_reg   <= (item_reg.dim == DIM_Y);
        end else if (state_reg == ST_DIV) begin
            if (cnt_reg == LAST_STEP) begin
                cnt_reg <= '0;
                if (pass2_reg) begin
                    // second pass: node / mesh_x, then modulo mesh_y
                    quo_reg     <= quo_step;
                    rem_reg     <= '0;
                    divisor_reg <= {4'd0, my};
                    pass2_reg   <= 1'b0;
                end else begin
                    loc_reg <= (item_reg.dim == DIM_Z) ? quo_step[LOC_W-1:0]
                                                       : rem_step[LOC_W-1:0];
                end
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
                quo_reg <= quo_step;
                rem_reg <= rem_step;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mefvu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mefvu_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mefvu_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 12288
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: tb/mefvu_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mefvu_result_check
// Watches the item, result and configuration ports of the mesh edge-flip
// vertex update block. Keeps its own copy of the accumulator table and the
// mesh sizes, works out the entry each accepted item should produce, and
// compares every accepted result with the oldest expected entry.
// ----------------------------------------------------------------------------
module mefvu_result_check #(
    parameter int unsigned MAX_NODES = mefvu_pkg::MAX_NODES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  mefvu_pkg::in_item_t                 s_item,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  mefvu_pkg::out_item_t                m_item,
    input  logic                                cfg_wr_en,
    input  logic [mefvu_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mefvu_pkg::MESH_W-1:0]        cfg_wr_data,
    output int unsigned                         n_fail,
    output int unsigned                         n_pending
);
    import mefvu_pkg::*;

    localparam int unsigned DEPTH   = 3 * MAX_NODES;
    localparam longint      ACC_TOP = 64'sd2147483647;
    localparam longint      ACC_BOT = -64'sd2147483648;

    // model state: accumulator table and mesh sizes as written
    entry_t              acc_table [DEPTH];
    logic [MESH_W-1:0]   size_x;
    logic [MESH_W-1:0]   size_y;
    logic [MESH_W-1:0]   size_z;

    out_item_t           entry_after_q [$];
    out_item_t           want;
    int unsigned         mismatch_count = 0;
    int unsigned         open_count = 0;

    assign n_fail    = mismatch_count;
    assign n_pending = open_count;

    // a size of zero acts as one, anything above 16 as 16
    function automatic int unsigned used_size(logic [MESH_W-1:0] v);
        if (v < MESH_MIN) return MESH_MIN;
        if (v > MESH_MAX) return MESH_MAX;
        return v;
    endfunction

    // saturating accumulate into 32 bits
    function automatic logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W-1:0] acc,
                                                         longint delta);
        longint s;
        s = longint'(acc) + delta;
        if (s > ACC_TOP) s = ACC_TOP;
        if (s < ACC_BOT) s = ACC_BOT;
        return s[ACC_W-1:0];
    endfunction

    // apply one item to the table and return the entry it leaves behind
    function automatic out_item_t apply_flip_item(in_item_t it);
        out_item_t   res;
        entry_t      e;
        int unsigned mx, my, mz, p, loc, idx;
        longint      w;
        res = '0;
        mx  = used_size(size_x);
        my  = used_size(size_y);
        mz  = used_size(size_z);
        p   = mx * my * mz;
        if (it.dim == DIM_NONE || p > MAX_NODES || it.neighbor >= p
                || it.home_node >= p) begin
            res.error = 1'b1;
            return res;
        end
        idx = it.dim * p + it.neighbor;
        e   = acc_table[idx];
        if (it.cmd == CMD_LOAD) begin
            e.same       = it.load_same;
            e.above      = it.load_above;
            e.below      = it.load_below;
            res.affected = 1'b1;
        end else begin
            // coordinate of the home node in the moved dimension
            case (it.dim)
                DIM_X:   loc = it.home_node % mx;
                DIM_Y:   loc = (it.home_node / mx) % my;
                default: loc = it.home_node / (mx * my);
            endcase
            w = it.weight;
            if (it.old_loc < loc && it.new_loc >= loc) begin
                e.same  = sat_acc(e.same, w);
                e.below = sat_acc(e.below, -w);
                res.affected = 1'b1;
            end else if (it.old_loc > loc && it.new_loc <= loc) begin
                e.same  = sat_acc(e.same, w);
                e.above = sat_acc(e.above, -w);
                res.affected = 1'b1;
            end else if (it.old_loc == loc && it.new_loc < loc) begin
                e.same  = sat_acc(e.same, -w);
                e.below = sat_acc(e.below, w);
                res.affected = 1'b1;
            end else if (it.old_loc == loc && it.new_loc > loc) begin
                e.same  = sat_acc(e.same, -w);
                e.above = sat_acc(e.above, w);
                res.affected = 1'b1;
            end
        end
        acc_table[idx]  = e;
        res.same_value  = e.same;
        res.above_value = e.above;
        res.below_value = e.below;
        return res;
    endfunction

    // sample all three ports on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (acc_table[i]) acc_table[i] = '0;
            size_x = MESH_MIN;
            size_y = MESH_MIN;
            size_z = MESH_MIN;
            entry_after_q.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MESH_X: size_x = cfg_wr_data;
                    CFG_MESH_Y: size_y = cfg_wr_data;
                    CFG_MESH_Z: size_z = cfg_wr_data;
                    default: ;
                endcase
            end
            // accepted input item
            if (s_valid && s_ready) entry_after_q.push_back(apply_flip_item(s_item));
            // accepted result item
            if (m_valid && m_ready) begin
                if (entry_after_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result item with nothing pending", $realtime);
                        $display("  actual   aff=%0b same=%0d above=%0d below=%0d err=%0b",
                                 m_item.affected, m_item.same_value, m_item.above_value,
                                 m_item.below_value, m_item.error);
                    end
                end else begin
                    want = entry_after_q.pop_front();
                    if (m_item.affected !== want.affected
                            || m_item.same_value !== want.same_value
                            || m_item.above_value !== want.above_value
                            || m_item.below_value !== want.below_value
                            || m_item.error !== want.error) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected aff=%0b same=%0d above=%0d below=%0d err=%0b",
                                     want.affected, want.same_value, want.above_value,
                                     want.below_value, want.error);
                            $display("  actual   aff=%0b same=%0d above=%0d below=%0d err=%0b",
                                     m_item.affected, m_item.same_value, m_item.above_value,
                                     m_item.below_value, m_item.error);
                        end
                    end
                end
            end
        end
        open_count = entry_after_q.size();
    end

endmodule

// File: tb/tb_mesh_edge_flip_vertex_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_edge_flip_vertex_update
// Drives load and edge-flip items into the block under several mesh sizes,
// directed corner cases first and then random items, with random idling on
// both channels, a long result stall and a full drain; a separate module
// checks every result.
// ----------------------------------------------------------------------------
module tb_mesh_edge_flip_vertex_update;
    import mefvu_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned ITEMS_PER_PHASE = 105;
    localparam int unsigned STALL_CYCLES  = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [MESH_W-1:0]     cfg_wr_data;
    int unsigned           n_fail;
    int unsigned           n_pending;

    // stimulus shaping state
    int unsigned           size_x = 1;
    int unsigned           size_y = 1;
    int unsigned           size_z = 1;
    bit                    calm = 1'b0;
    int unsigned           stall_req = 0;
    int unsigned           stall_seen = 0;
    int unsigned           stall_left = 0;

    mesh_edge_flip_vertex_update dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    mefvu_result_check result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .n_fail      (n_fail),
        .n_pending   (n_pending)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side ready: random holdoff, long stall on request
    always @(negedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 32);
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL mesh_edge_flip_vertex_update");
        $finish;
    end

    function automatic int unsigned used_size(logic [MESH_W-1:0] v);
        if (v < MESH_MIN) return MESH_MIN;
        if (v > MESH_MAX) return MESH_MAX;
        return v;
    endfunction

    // mix of small, arbitrary and near-saturation values
    function automatic logic signed [ACC_W-1:0] rand_acc();
        logic signed [ACC_W-1:0] v;
        case ($urandom_range(0, 2))
            0: begin
                v = $urandom_range(0, 'h3FFFF);
                if ($urandom_range(0, 1)) v = -v;
            end
            1:       v = $urandom;
            default: v = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000)
                         | $urandom_range(0, 'hFFFF);
        endcase
        return v;
    endfunction

    // mostly near the mesh extent so the update cases come up often
    function automatic logic [LOC_W-1:0] pick_loc(int unsigned span);
        if ($urandom_range(0, 3) != 0) return LOC_W'($urandom_range(0, (span > 15) ? 15 : span));
        return LOC_W'($urandom_range(0, 15));
    endfunction

    function automatic in_item_t flip_item(logic [LOC_W-1:0] old_loc,
                                           logic [LOC_W-1:0] new_loc,
                                           logic [DIM_W-1:0] dim,
                                           logic signed [ACC_W-1:0] weight,
                                           logic [NODE_W-1:0] neighbor,
                                           logic [NODE_W-1:0] node);
        in_item_t it;
        it.cmd           = CMD_UPDATE;
        it.old_loc       = old_loc;
        it.new_loc       = new_loc;
        it.dim           = dim;
        it.weight        = weight;
        it.neighbor      = neighbor;
        it.home_node     = node;
        it.load_same     = $urandom;
        it.load_above    = $urandom;
        it.load_below    = $urandom;
        return it;
    endfunction

    function automatic in_item_t load_item(logic [DIM_W-1:0] dim,
                                           logic [NODE_W-1:0] neighbor,
                                           logic [NODE_W-1:0] node,
                                           logic signed [ACC_W-1:0] same,
                                           logic signed [ACC_W-1:0] above,
                                           logic signed [ACC_W-1:0] below);
        in_item_t it;
        it = flip_item(LOC_W'($urandom), LOC_W'($urandom), dim, $urandom, neighbor, node);
        it.cmd        = CMD_LOAD;
        it.load_same  = same;
        it.load_above = above;
        it.load_below = below;
        return it;
    endfunction

    // mostly in-mesh items with random content, some out-of-mesh noise
    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned p, span;
        p = size_x * size_y * size_z;
        it.cmd = ($urandom_range(0, 99) < 25) ? CMD_LOAD : CMD_UPDATE;
        it.dim = DIM_W'($urandom_range(0, 2));
        case (it.dim)
            DIM_X:   span = size_x;
            DIM_Y:   span = size_y;
            default: span = size_z;
        endcase
        it.old_loc       = pick_loc(span);
        it.new_loc       = pick_loc(span);
        it.weight        = rand_acc();
        it.neighbor      = NODE_W'($urandom_range(0, p - 1));
        it.home_node     = NODE_W'($urandom_range(0, p - 1));
        it.load_same     = rand_acc();
        it.load_above    = rand_acc();
        it.load_below    = rand_acc();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: it.dim = DIM_NONE;
                1: if (p < 4096) it.neighbor = NODE_W'($urandom_range(p, 4095));
                   else it.dim = DIM_NONE;
                2: if (p < 4096) it.home_node = NODE_W'($urandom_range(p, 4095));
                   else it.dim = DIM_NONE;
                default: begin
                    it.dim           = DIM_W'($urandom);
                    it.old_loc       = LOC_W'($urandom);
                    it.new_loc       = LOC_W'($urandom);
                    it.neighbor      = NODE_W'($urandom);
                    it.home_node     = NODE_W'($urandom);
                end
            endcase
        end
        return it;
    endfunction

    // offer one item, holding it until taken
    task automatic send_item(in_item_t it);
        @(negedge aclk);
        if (!calm) begin
            while ($urandom_range(0, 99) < 32) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
    endtask

    // write all three mesh sizes, block idle
    task automatic set_mesh(logic [MESH_W-1:0] x, logic [MESH_W-1:0] y,
                            logic [MESH_W-1:0] z);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_MESH_X;
        cfg_wr_data <= x;
        @(negedge aclk);
        cfg_addr    <= CFG_MESH_Y;
        cfg_wr_data <= y;
        @(negedge aclk);
        cfg_addr    <= CFG_MESH_Z;
        cfg_wr_data <= z;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        size_x = used_size(x);
        size_y = used_size(y);
        size_z = used_size(z);
    endtask

    function automatic logic [MESH_W-1:0] rand_size();
        if ($urandom_range(0, 9) == 0) return MESH_W'($urandom_range(0, 31));
        return MESH_W'($urandom_range(1, 5));
    endfunction

    // main sequence
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_MESH_X;
        cfg_wr_data = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // 4 x 3 x 2 mesh: every update case, saturation, rejects
        set_mesh(4, 3, 2);
        send_item(load_item(DIM_X, 5, 23, ACC_MAX, ACC_MIN, 0));
        send_item(flip_item(0, 3, DIM_X, 1, 5, 7));          // moves up onto the node
        send_item(flip_item(15, 3, DIM_X, ACC_MIN, 5, 7));   // moves down onto the node
        send_item(flip_item(3, 0, DIM_X, ACC_MAX, 5, 7));    // leaves it downward
        send_item(flip_item(3, 15, DIM_X, ACC_MIN, 5, 7));   // leaves it upward
        send_item(flip_item(3, 3, DIM_X, 100, 5, 7));        // stays on it
        send_item(flip_item(0, 2, DIM_X, 100, 5, 7));        // stays below
        send_item(flip_item(15, 4, DIM_X, 100, 5, 7));       // stays above
        send_item(flip_item(1, 2, DIM_Y, -1, 23, 23));
        send_item(flip_item(0, 1, DIM_Z, 0, 23, 23));
        send_item(flip_item(2, 0, DIM_NONE, 5, 0, 0));
        send_item(load_item(DIM_NONE, 0, 0, 1, 2, 3));
        send_item(flip_item(0, 1, DIM_X, 5, 24, 0));          // vertex past the mesh
        send_item(load_item(DIM_Y, 4095, 0, 1, 2, 3));
        send_item(flip_item(0, 1, DIM_X, 5, 0, 24));          // node past the mesh
        send_item(load_item(DIM_Z, 0, 4095, 1, 2, 3));
        send_item(load_item(DIM_Z, 23, 0, 0, 0, 0));
        send_item(load_item(DIM_Z, 23, 0, -1, -1, -1));

        // zero and oversized register values
        wait_drained();
        set_mesh(0, 31, 17);
        send_item(flip_item(14, 15, DIM_Y, 32'sh0001_8000, 255, 255));
        send_item(flip_item(0, 5, DIM_X, 32'sh0001_0000, 0, 100));
        send_item(flip_item(15, 0, DIM_Z, ACC_MAX, 255, 255));

        // largest mesh, top vertex and node
        wait_drained();
        set_mesh(16, 16, 16);
        send_item(load_item(DIM_Z, 4095, 4095, ACC_MAX, ACC_MAX, ACC_MIN));
        send_item(flip_item(15, 0, DIM_Z, ACC_MAX, 4095, 4095));
        send_item(flip_item(0, 15, DIM_Y, ACC_MIN, 2048, 4095));
        send_item(flip_item(3, 3, DIM_X, 1, 4095, 0));

        // random phases, each under its own mesh
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       set_mesh(1, 1, 1);
                1:       set_mesh(16, 16, 16);
                2:       set_mesh(31, 0, 17);
                default: set_mesh(rand_size(), rand_size(), rand_size());
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                calm = (ph == 4 && k < 80);
                if (ph == 3 && k == 30) stall_req++;
                if (ph == 5 && k == 50) wait_drained();
                send_item(rand_item());
            end
            calm = 1'b0;
        end

        // drain, then let the pipeline settle
        @(negedge aclk);
        s_valid <= 1'b0;
        for (int i = 0; i < 100000 && n_pending != 0; i++) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("PASS mesh_edge_flip_vertex_update");
        end else begin
            $display("FAIL mesh_edge_flip_vertex_update");
        end
        $finish;
    end

endmodule
